/* src/btms_pkg.sv */
`timescale 1ns / 1ps
package btms_pkg;
	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_ADD      = 2'd1,
		CMD_FINALIZE = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_MIN_CONF = 2'd0,
		CFG_ALPHA    = 2'd1,
		CFG_MAX_STEP = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_SCAN,
		ST_DIV,
		ST_STEP,
		ST_MUL,
		ST_ROUND,
		ST_DONE
	} state_t;

	localparam int unsigned ONE_Q16 = 65536;
	localparam int unsigned LVL_W = 20;

	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} cell_ctl_t;
endpackage

/* src/btms_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted insertion row. Each cell keeps one value and its
// occupied bit; an insert puts the new value into its ordered place, and a
// shift rotates the row one place towards the head for readout. The head
// cell sees its predecessor as occupied.
module btms_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  btms_pkg::cell_ctl_t           ctl,
	input  logic signed [btms_pkg::LVL_W-1:0] new_val,
	input  logic signed [btms_pkg::LVL_W-1:0] prev_val,
	input  logic                          prev_occ,
	input  logic                          prev_gt,
	input  logic signed [btms_pkg::LVL_W-1:0] next_val,
	input  logic                          next_occ,
	output logic signed [btms_pkg::LVL_W-1:0] val,
	output logic                          occ,
	output logic                          gt
);
	import btms_pkg::*;

	logic signed [LVL_W-1:0] val_q;
	logic                    occ_q;

	// occupied and greater than the new value: this cell must move up
	assign gt  = occ_q && (val_q > new_val);
	assign val = val_q;
	assign occ = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.insert) begin
			if (gt || (!occ_q && prev_occ)) begin
				occ_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			occ_q <= next_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (gt || (!occ_q && prev_occ)) begin
				val_q <= prev_gt ? prev_val : new_val;
			end
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
	end
endmodule

/* src/btms_divider.sv */
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module btms_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [27:0] dividend,
	input  logic        [6:0]  divisor,
	output logic               done,
	output logic signed [27:0] quotient
);
	import btms_pkg::*;

	logic [27:0] num_q;
	logic [27:0] rem_q;
	logic [6:0]  den_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [28:0] trial;
	logic [27:0] rem_sh;

	assign rem_sh = {rem_q[26:0], num_q[27]};
	assign trial  = {1'b0, rem_sh} - {22'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd27;
			end else if (run_q) begin
				if (cnt_q == 5'd0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[27];
			num_q <= dividend[27] ? 28'(-dividend) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[26:0], !trial[28]};
			rem_q <= trial[28] ? rem_sh : trial[27:0];
		end
	end

	assign quotient = neg_q ? 28'(-$signed(num_q)) : $signed(num_q);
endmodule

/* src/burst_trimmed_mean_smoother_unit.sv */
`timescale 1ns / 1ps
// Channel   Handshake            Content
// command   start/busy           command, head_sample, confidence, sample_finite
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
// result    result_valid         frame_accepted .. step_alarm, one cycle
// Start, add and the unused command go straight to the done state. Finalize
// holds busy through a full rotation of the sorted cell row, a 28-step divider
// and a two-step smoother multiply, or skips to done for an empty burst.
// The result is valid in the cycle in which busy falls. Reset clears the state
// machine, counters, smoother and cell row at once. Results cannot be stalled.
module burst_trimmed_mean_smoother_unit #(
	parameter int MAX_FRAMES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [19:0] head_sample,
	input  logic [16:0]        confidence,
	input  logic               sample_finite,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [18:0]        cfg_data,
	output logic               result_valid,
	output logic               frame_accepted,
	output logic [5:0]         frames_stored,
	output logic [5:0]         frames_passed,
	output logic signed [19:0] burst_median,
	output logic signed [19:0] burst_trimmed_mean,
	output logic signed [19:0] smoothed_level,
	output logic               step_alarm
);
	import btms_pkg::*;

	localparam int CW = $clog2(MAX_FRAMES + 1);

	logic [16:0] min_conf_q, alpha_q;
	logic [18:0] max_step_q;
	logic [CW-1:0] stored_q, passed_q;
	logic signed [19:0] smooth_q, last_q;
	logic primed_q;

	state_t st_q, st_d;
	logic [CW-1:0] rd_q;
	logic signed [27:0] sum_q;
	logic signed [19:0] lo_q, med_q, tmean_q;
	logic [CW-1:0] n_q, trim_q;
	logic alarm_q, acc_q, is_fin_q;
	logic [16:0] a_q;
	logic signed [37:0] p1_q, p2_q;

	cell_ctl_t ctl;
	logic signed [19:0] cval [MAX_FRAMES];
	logic               cocc [MAX_FRAMES];
	logic               cgt  [MAX_FRAMES];

	logic div_start, div_done;
	logic signed [27:0] div_q;

	assign cfg_ready = 1'b1;
	assign busy = (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= 17'd32768;
			alpha_q    <= 17'd19661;
			max_step_q <= 19'd2048;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_CONF: min_conf_q <= cfg_data[16:0];
				CFG_ALPHA:    alpha_q <= cfg_data[16:0];
				CFG_MAX_STEP: max_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_FRAMES; g++) begin : g_cell
			btms_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .new_val(head_sample),
				.prev_val(g == 0 ? 20'sd0 : cval[g == 0 ? 0 : g - 1]),
				.prev_occ(g == 0 ? 1'b1 : cocc[g == 0 ? 0 : g - 1]),
				.prev_gt(g == 0 ? 1'b0 : cgt[g == 0 ? 0 : g - 1]),
				.next_val(cval[(g + 1) % MAX_FRAMES]),
				.next_occ(cocc[(g + 1) % MAX_FRAMES]),
				.val(cval[g]), .occ(cocc[g]), .gt(cgt[g])
			);
		end
	endgenerate

	logic [CW-1:0] kept;
	assign kept = n_q - trim_q - trim_q;

	btms_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_q), .divisor(7'(kept)), .done(div_done), .quotient(div_q)
	);

	logic ok_add;
	assign ok_add = sample_finite && confidence >= min_conf_q && confidence <= 17'(ONE_Q16);

	logic signed [20:0] diff;
	logic [20:0] adiff;
	assign diff  = 21'(tmean_q) - 21'(last_q);
	assign adiff = diff[20] ? 21'(-diff) : diff;

	logic signed [39:0] rsum;
	assign rsum = 40'(p1_q) + 40'(p2_q) + 40'sd32768;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (start) st_d = (command == CMD_FINALIZE) ? ST_SORT : ST_DONE;
			ST_SORT:  st_d = (n_q == '0) ? ST_DONE : ST_SCAN;
			ST_SCAN:  if (rd_q == CW'(MAX_FRAMES)) st_d = ST_DIV;
			ST_DIV:   if (div_done) st_d = ST_STEP;
			ST_STEP:  st_d = ST_MUL;
			ST_MUL:   st_d = ST_ROUND;
			ST_ROUND: st_d = ST_DONE;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		div_start = 1'b0;
		if (st_q == ST_IDLE && start && command == CMD_START) ctl.clear = 1'b1;
		if (st_q == ST_IDLE && start && command == CMD_ADD && ok_add
			&& stored_q < CW'(MAX_FRAMES) && min_conf_q <= 17'(ONE_Q16)) ctl.insert = 1'b1;
		if (st_q == ST_SCAN && rd_q != CW'(MAX_FRAMES)) ctl.shift = 1'b1;
		if (st_q == ST_SCAN && rd_q == CW'(MAX_FRAMES)) div_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			stored_q <= '0;
			passed_q <= '0;
			smooth_q <= '0;
			last_q <= '0;
			primed_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			result_valid <= (st_q == ST_DONE);
			if (st_q == ST_IDLE && start) begin
				if (command == CMD_START) begin
					stored_q <= '0;
					passed_q <= '0;
				end else if (command == CMD_ADD && stored_q < CW'(MAX_FRAMES)
					&& min_conf_q <= 17'(ONE_Q16)) begin
					stored_q <= stored_q + 1'b1;
					if (ok_add) passed_q <= passed_q + 1'b1;
				end
			end
			if (st_q == ST_STEP && !alarm_q && !(last_q > 20'sd4 && adiff > 21'(max_step_q))
				&& !primed_q) begin
				smooth_q <= tmean_q;
				last_q <= tmean_q;
				primed_q <= 1'b1;
			end
			if (st_q == ST_ROUND && !alarm_q) begin
				smooth_q <= rsum[35:16];
				last_q <= rsum[35:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			is_fin_q <= (command == CMD_FINALIZE);
			acc_q <= (command == CMD_ADD) && ok_add && stored_q < CW'(MAX_FRAMES)
				&& min_conf_q <= 17'(ONE_Q16);
			alarm_q <= 1'b0;
			n_q <= passed_q;
			trim_q <= (passed_q < CW'(3)) ? '0 : CW'((passed_q * 205) >> 10);
			rd_q <= '0;
			sum_q <= '0;
			med_q <= '0;
			tmean_q <= '0;
			a_q <= (alpha_q > 17'(ONE_Q16)) ? 17'(ONE_Q16) : alpha_q;
		end
		if (st_q == ST_SORT && n_q == '0) begin
			med_q <= last_q;
			tmean_q <= last_q;
			alarm_q <= 1'b1;
		end
		if (ctl.shift) begin
			rd_q <= rd_q + 1'b1;
			if (rd_q >= trim_q && rd_q < n_q - trim_q) sum_q <= sum_q + 28'(cval[0]);
			if (rd_q == CW'((n_q - 1'b1) >> 1)) lo_q <= cval[0];
			if (rd_q == (n_q >> 1)) begin
				if (n_q[0]) med_q <= cval[0];
				else med_q <= 20'((21'(lo_q) + 21'(cval[0])) / 2);
			end
		end
		if (st_q == ST_DIV && div_done) tmean_q <= div_q[19:0];
		if (st_q == ST_STEP) begin
			if (last_q > 20'sd4 && adiff > 21'(max_step_q)) alarm_q <= 1'b1;
			else if (!primed_q) alarm_q <= 1'b1;
		end
		if (st_q == ST_MUL) begin
			p1_q <= $signed({1'b0, a_q}) * tmean_q;
			p2_q <= $signed({1'b0, 17'(ONE_Q16) - a_q}) * smooth_q;
		end
	end

	// alarm_q is reused after STEP to skip the rounding for a first load
	logic fin_alarm_q;
	always_ff @(posedge clk) begin
		if (st_q == ST_STEP) fin_alarm_q <= last_q > 20'sd4 && adiff > 21'(max_step_q);
		if (st_q == ST_SORT) fin_alarm_q <= (n_q == '0);
		if (st_q == ST_IDLE && start) fin_alarm_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE) begin
			frame_accepted <= acc_q;
			frames_stored <= 6'(stored_q);
			frames_passed <= 6'(passed_q);
			burst_median <= is_fin_q ? med_q : '0;
			burst_trimmed_mean <= is_fin_q ? tmean_q : '0;
			smoothed_level <= smooth_q;
			step_alarm <= is_fin_q && fin_alarm_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> !busy);
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n) passed_q <= stored_q)
		else $error("count order");
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import btms_pkg::*;

	localparam int NFRAMES = 32;

	typedef struct packed {
		logic               accepted;
		logic [5:0]         total;
		logic [5:0]         passed;
		logic signed [19:0] median;
		logic signed [19:0] tmean;
		logic signed [19:0] level;
		logic               alarm;
	} burst_res_t;

	typedef struct {
		cmd_t               cmd;
		logic signed [19:0] head;
		logic [16:0]        conf;
		logic               finite;
		logic               has_exp;
		burst_res_t         exp_res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = 2'd0;
	logic signed [19:0] head_sample = '0;
	logic [16:0]        confidence = '0;
	logic               sample_finite = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 2'd0;
	logic [18:0]        cfg_data = '0;
	logic               result_valid;
	logic               frame_accepted;
	logic [5:0]         frames_stored;
	logic [5:0]         frames_passed;
	logic signed [19:0] burst_median;
	logic signed [19:0] burst_trimmed_mean;
	logic signed [19:0] smoothed_level;
	logic               step_alarm;

	burst_trimmed_mean_smoother_unit #(.MAX_FRAMES(NFRAMES)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .head_sample(head_sample), .confidence(confidence),
		.sample_finite(sample_finite), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
		.frame_accepted(frame_accepted), .frames_stored(frames_stored),
		.frames_passed(frames_passed), .burst_median(burst_median),
		.burst_trimmed_mean(burst_trimmed_mean), .smoothed_level(smoothed_level),
		.step_alarm(step_alarm)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [16:0]        gate_conf;
	logic [16:0]        alpha;
	logic [18:0]        step_limit;
	logic signed [19:0] store_lvl [NFRAMES];
	logic               store_ok [NFRAMES];
	int                 n_stored;
	int                 n_passed;
	logic signed [19:0] smooth_val;
	logic               smooth_primed;
	logic signed [19:0] good_level;

	burst_res_t expected_q[$];
	int         errors = 0;
	int         n_sent = 0;

	function automatic burst_res_t predict_burst(cmd_t cmd, logic signed [19:0] head,
			logic [16:0] conf, logic fin);
		burst_res_t r;
		logic signed [19:0] v[$];
		logic signed [19:0] t;
		longint sum, a, s, dh;
		int trim, cnt;
		logic ok;
		r = '0;
		case (cmd)
			CMD_START: begin
				foreach (store_ok[i]) store_ok[i] = 1'b0;
				n_stored = 0;
				n_passed = 0;
			end
			CMD_ADD: begin
				if (n_stored < NFRAMES && gate_conf <= ONE_Q16) begin
					ok = fin && conf >= gate_conf && conf <= ONE_Q16;
					store_lvl[n_stored] = head;
					store_ok[n_stored] = ok;
					n_stored++;
					if (ok) begin
						n_passed++;
						r.accepted = 1'b1;
					end
				end
			end
			CMD_FINALIZE: begin
				if (n_passed == 0) begin
					r.median = good_level;
					r.tmean = good_level;
					r.alarm = 1'b1;
				end else begin
					for (int i = 0; i < n_stored; i++)
						if (store_ok[i]) v.push_back(store_lvl[i]);
					for (int i = 1; i < v.size(); i++)
						for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
							t = v[j]; v[j] = v[j-1]; v[j-1] = t;
						end
					cnt = v.size();
					if (cnt % 2) r.median = v[cnt/2];
					else r.median = 20'((longint'(v[cnt/2-1]) + longint'(v[cnt/2])) / 2);
					trim = (cnt < 3) ? 0 : cnt / 5;
					sum = 0;
					for (int i = trim; i < cnt - trim; i++) sum += v[i];
					r.tmean = 20'(sum / longint'(cnt - 2 * trim));
					if (good_level > 4) begin
						dh = longint'(r.tmean) - longint'(good_level);
						if (dh < 0) dh = -dh;
						if (dh > longint'(step_limit)) r.alarm = 1'b1;
					end
					if (!r.alarm) begin
						if (!smooth_primed) begin
							smooth_val = r.tmean;
							smooth_primed = 1'b1;
						end else begin
							a = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
							s = a * longint'(r.tmean)
								+ (longint'(ONE_Q16) - a) * longint'(smooth_val) + 32768;
							smooth_val = 20'(s >>> 16);
						end
						good_level = smooth_val;
					end
				end
			end
			default: ;
		endcase
		r.total = 6'(n_stored);
		r.passed = 6'(n_passed);
		r.level = smooth_val;
		return r;
	endfunction

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_cmd(cmd_t cmd, logic signed [19:0] head, logic [16:0] conf,
			logic fin, logic has_exp, burst_res_t exp_res);
		burst_res_t p;
		command <= cmd;
		head_sample <= head;
		confidence <= conf;
		sample_finite <= fin;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		n_sent++;
		p = predict_burst(cmd, head, conf, fin);
		expected_q.push_back(has_exp ? exp_res : p);
		@(posedge clk);
	endtask

	task automatic drain(int tail);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [18:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MIN_CONF: gate_conf = val[16:0];
			CFG_ALPHA:    alpha = val[16:0];
			default:      step_limit = val;
		endcase
		@(posedge clk);
	endtask

	function automatic burst_res_t res(logic acc, int tot, int pas, int med, int tm,
			int lvl, logic alm);
		burst_res_t r;
		r.accepted = acc; r.total = 6'(tot); r.passed = 6'(pas);
		r.median = 20'(med); r.tmean = 20'(tm); r.level = 20'(lvl); r.alarm = alm;
		return r;
	endfunction

	// checker
	always @(posedge clk) begin
		burst_res_t e;
		if (result_valid) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (frame_accepted !== e.accepted) begin
					$error("frame_accepted exp %0d got %0d", e.accepted, frame_accepted); errors++;
				end
				if (frames_stored !== e.total) begin
					$error("frames_stored exp %0d got %0d", e.total, frames_stored); errors++;
				end
				if (frames_passed !== e.passed) begin
					$error("frames_passed exp %0d got %0d", e.passed, frames_passed); errors++;
				end
				if (burst_median !== e.median) begin
					$error("burst_median exp %0d got %0d", e.median, burst_median); errors++;
				end
				if (burst_trimmed_mean !== e.tmean) begin
					$error("burst_trimmed_mean exp %0d got %0d", e.tmean, burst_trimmed_mean);
					errors++;
				end
				if (smoothed_level !== e.level) begin
					$error("smoothed_level exp %0d got %0d", e.level, smoothed_level); errors++;
				end
				if (step_alarm !== e.alarm) begin
					$error("step_alarm exp %0d got %0d", e.alarm, step_alarm); errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic random_burst();
		int n;
		logic [16:0] c;
		logic signed [19:0] base;
		send_cmd(CMD_START, 20'($urandom), 17'($urandom), 1'($urandom), 1'b0, '0);
		idle_gap();
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 9);
		base = 20'($urandom_range(0, 40000));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: c = 17'($urandom);
				1: c = gate_conf;
				2: c = 17'(ONE_Q16);
				default: c = 17'($urandom_range(gate_conf > ONE_Q16 ? 0 : gate_conf, ONE_Q16));
			endcase
			send_cmd(CMD_ADD,
				($urandom_range(0, 5) == 0) ? 20'($urandom) : 20'(base + $urandom_range(0, 4000) - 2000),
				c, $urandom_range(0, 7) != 0, 1'b0, '0);
			idle_gap();
		end
		if ($urandom_range(0, 9) == 0) begin
			send_cmd(CMD_NONE, 20'($urandom), 17'($urandom), 1'($urandom), 1'b0, '0);
			idle_gap();
		end
		send_cmd(CMD_FINALIZE, 20'($urandom), 17'($urandom), 1'($urandom), 1'b0, '0);
		idle_gap();
	endtask

	initial begin
		row_t rows[$];
		logic [18:0] cfg_sets[5][3];
		gate_conf = 17'd32768;
		alpha = 17'd19661;
		step_limit = 19'd2048;
		foreach (store_ok[i]) begin
			store_ok[i] = 1'b0;
			store_lvl[i] = '0;
		end
		n_stored = 0; n_passed = 0;
		smooth_val = '0; smooth_primed = 1'b0; good_level = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{CMD_NONE, 20'sd0, 17'd0, 1'b0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)},
			'{CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b1, res(0, 0, 0, 0, 0, 0, 1)},
			'{CMD_START, 20'sd0, 17'd0, 1'b0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sh7FFFF, 17'd65536, 1'b1, 1'b1, res(1, 1, 1, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sh80000, 17'd32768, 1'b1, 1'b1, res(1, 2, 2, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sd100, 17'd32767, 1'b1, 1'b1, res(0, 3, 2, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sd100, 17'd65537, 1'b1, 1'b1, res(0, 4, 2, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sd100, 17'h1FFFF, 1'b1, 1'b1, res(0, 5, 2, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sd100, 17'd40000, 1'b0, 1'b1, res(0, 6, 2, 0, 0, 0, 0)},
			'{CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b0, '0},
			'{CMD_START, 20'sd0, 17'd0, 1'b0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)},
			'{CMD_ADD, 20'sd8192, 17'd50000, 1'b1, 1'b0, '0},
			'{CMD_ADD, 20'sd4096, 17'd50000, 1'b1, 1'b0, '0},
			'{CMD_ADD, 20'sd6000, 17'd50000, 1'b1, 1'b0, '0},
			'{CMD_ADD, 20'sd5000, 17'd50000, 1'b1, 1'b0, '0},
			'{CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b0, '0},
			'{CMD_START, 20'sd0, 17'd0, 1'b0, 1'b0, '0},
			'{CMD_ADD, 20'sd40000, 17'd60000, 1'b1, 1'b0, '0},
			'{CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b0, '0},
			'{CMD_START, 20'sd0, 17'd0, 1'b0, 1'b0, '0},
			'{CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b0, '0}
		};
		foreach (rows[i])
			send_cmd(rows[i].cmd, rows[i].head, rows[i].conf, rows[i].finite,
				rows[i].has_exp, rows[i].exp_res);
		drain(100);

		// store overflow and gate above one
		write_reg(CFG_MIN_CONF, 19'd65537);
		send_cmd(CMD_ADD, 20'sd5, 17'd65536, 1'b1, 1'b0, '0);
		drain(100);
		write_reg(CFG_MIN_CONF, 19'd0);
		send_cmd(CMD_START, 20'sd0, 17'd0, 1'b0, 1'b0, '0);
		for (int i = 0; i < NFRAMES + 3; i++)
			send_cmd(CMD_ADD, 20'(i * 97 - 1500), 17'(i * 1900), 1'b1, 1'b0, '0);
		send_cmd(CMD_FINALIZE, 20'sd0, 17'd0, 1'b0, 1'b0, '0);
		drain(100);

		cfg_sets = '{
			'{19'd32768, 19'd19661, 19'd2048},
			'{19'd0, 19'd65536, 19'h7FFFF},
			'{19'd65536, 19'd0, 19'd0},
			'{19'd20000, 19'h1FFFF, 19'd500},
			'{19'd131071, 19'd40000, 19'd8000}
		};
		while (n_sent < 1250) begin
			for (int k = 0; k < 3; k++)
				write_reg(cfg_idx_t'(k), cfg_sets[$urandom_range(0, 4)][k]);
			for (int b = 0; b < 20 && n_sent < 1250; b++)
				random_burst();
			drain(100);
		end
		drain(120);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* files.f */
src/btms_pkg.sv
src/btms_cell.sv
src/btms_divider.sv
src/burst_trimmed_mean_smoother_unit.sv
tb/tb_top.sv
